/* src/pbts_pkg.sv */
// shared types, constants and register map of the priority bitmap task scheduler
`timescale 1ns / 1ps

package pbts_pkg;

    // sizes
    localparam int TASK_COUNT  = 32;
    localparam int LEVEL_COUNT = 16;
    localparam int TASK_W      = $clog2(TASK_COUNT);
    localparam int LVL_W       = $clog2(LEVEL_COUNT);
    localparam int BUD_W       = 16;

    // stream word widths
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_SLICE_COST    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROTATE_LEVEL  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXEMPT_FIRST  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_EXEMPT_SECOND = 2'd3;

    // register reset values
    localparam logic [BUD_W-1:0]  RST_SLICE_COST    = 16'd500;
    localparam logic [LVL_W-1:0]  RST_ROTATE_LEVEL  = 4'd1;
    localparam logic [TASK_W-1:0] RST_EXEMPT_FIRST  = 5'd1;
    localparam logic [TASK_W-1:0] RST_EXEMPT_SECOND = 5'd2;

    // operation codes
    typedef enum logic [1:0] {
        OP_SET_STATUS  = 2'd0,
        OP_SCHEDULE    = 2'd1,
        OP_LOAD_BUDGET = 2'd2,
        OP_PREEMPT     = 2'd3
    } t_op;

    // one input word
    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_id;
        logic [LVL_W-1:0]  priority_req;
        logic              to_runqueue;
        logic [BUD_W-1:0]  budget;
        logic [LVL_W-1:0]  other_priority;
        logic              in_interrupt;
    } t_item;

    // one result word
    typedef struct packed {
        logic [TASK_W-1:0] picked_task;
        logic              idle;
        logic              changed;
        logic              exited;
        logic              yield_now;
        logic              switch_pending;
        logic [BUD_W-1:0]  picked_budget;
    } t_result;

    // configuration registers
    typedef struct packed {
        logic [BUD_W-1:0]  slice_cost;
        logic [LVL_W-1:0]  rotate_level;
        logic [TASK_W-1:0] exempt_first;
        logic [TASK_W-1:0] exempt_second;
    } t_cfg;

endpackage

/* src/pbts_engine.sv */
// scheduler state (level lists, bitmap, budgets) and the per-word update logic
`timescale 1ns / 1ps

module pbts_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  pbts_pkg::t_item i_item,
    input  pbts_pkg::t_cfg  i_cfg,
    output pbts_pkg::t_result o_result
);
    import pbts_pkg::*;

    // scheduler state
    logic [LEVEL_COUNT-1:0] r_bitmap, n_bitmap;
    logic [TASK_W-1:0]      r_head [LEVEL_COUNT];
    logic [TASK_W-1:0]      n_head [LEVEL_COUNT];
    logic [TASK_W-1:0]      r_tail [LEVEL_COUNT];
    logic [TASK_W-1:0]      n_tail [LEVEL_COUNT];
    logic [TASK_W-1:0]      r_next [TASK_COUNT];
    logic [TASK_W-1:0]      n_next [TASK_COUNT];
    logic [LVL_W-1:0]       r_level [TASK_COUNT];
    logic [LVL_W-1:0]       n_level [TASK_COUNT];
    logic [TASK_COUNT-1:0]  r_onq, n_onq;
    logic [BUD_W-1:0]       r_budget [TASK_COUNT];
    logic [BUD_W-1:0]       n_budget [TASK_COUNT];
    logic [TASK_W-1:0]      r_active, n_active;
    logic                   r_active_vld, n_active_vld;
    logic                   r_sw_req, n_sw_req;

    // lowest non-empty level
    logic [LVL_W-1:0] w_win_lv;
    always_comb begin
        w_win_lv = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (r_bitmap[i]) begin
                w_win_lv = LVL_W'(i);
            end
        end
    end

    // next state and result for the word in flight
    always_comb begin
        logic [LVL_W-1:0]  v_lv;
        logic [LVL_W-1:0]  v_rl;
        logic [TASK_W-1:0] v_t;
        logic [TASK_W-1:0] v_pick;
        logic [TASK_W-1:0] v_h;
        logic              v_exempt;
        logic              v_exit;
        logic [BUD_W-1:0]  v_b;
        logic [BUD_W-1:0]  v_pbud;
        logic [BUD_W:0]    v_diff;
        logic              v_take;

        n_bitmap     = r_bitmap;
        n_head       = r_head;
        n_tail       = r_tail;
        n_next       = r_next;
        n_level      = r_level;
        n_onq        = r_onq;
        n_budget     = r_budget;
        n_active     = r_active;
        n_active_vld = r_active_vld;
        n_sw_req     = r_sw_req;
        o_result     = '0;

        v_lv     = '0;
        v_rl     = i_cfg.rotate_level;
        v_t      = i_item.task_id;
        v_pick   = '0;
        v_h      = '0;
        v_exempt = 1'b0;
        v_exit   = 1'b0;
        v_b      = '0;
        v_pbud   = '0;
        v_diff   = '0;
        v_take   = 1'b0;

        case (i_item.op)
            OP_SET_STATUS: begin
                if (i_item.to_runqueue) begin
                    // append at the tail of the requested level
                    if (!r_onq[v_t]) begin
                        v_lv = i_item.priority_req;
                        n_level[v_t] = v_lv;
                        if (!r_bitmap[v_lv]) begin
                            n_head[v_lv]   = v_t;
                            n_tail[v_lv]   = v_t;
                            n_bitmap[v_lv] = 1'b1;
                        end else begin
                            n_next[r_tail[v_lv]] = v_t;
                            n_tail[v_lv]         = v_t;
                        end
                        n_onq[v_t] = 1'b1;
                    end
                end else if (r_onq[v_t]) begin
                    // pop the head of the task's stored level
                    v_lv = r_level[v_t];
                    if (r_bitmap[v_lv]) begin
                        if (r_head[v_lv] == r_tail[v_lv]) begin
                            n_bitmap[v_lv] = 1'b0;
                        end else begin
                            n_head[v_lv] = r_next[r_head[v_lv]];
                        end
                    end
                    n_onq[v_t] = 1'b0;
                end
            end
            OP_SCHEDULE: begin
                n_sw_req = 1'b0;
                if (r_bitmap == '0) begin
                    o_result.idle    = 1'b1;
                    o_result.changed = r_active_vld;
                    n_active_vld     = 1'b0;
                end else begin
                    v_lv     = w_win_lv;
                    v_pick   = r_head[v_lv];
                    v_exempt = (v_pick == i_cfg.exempt_first) ||
                               (v_pick == i_cfg.exempt_second);
                    v_b      = r_budget[v_pick];
                    v_pbud   = v_b;
                    // charge the slice, saturating at zero
                    if (r_active_vld && !v_exempt) begin
                        v_diff = {1'b0, v_b} - {1'b0, i_cfg.slice_cost};
                        v_pbud = v_diff[BUD_W] ? '0 : v_diff[BUD_W-1:0];
                        n_budget[v_pick] = v_pbud;
                    end
                    // task switch, with exit on an empty budget
                    if (!r_active_vld || (r_active != v_pick)) begin
                        o_result.changed = 1'b1;
                        n_active         = v_pick;
                        n_active_vld     = 1'b1;
                        if ((v_pbud == '0) && !v_exempt) begin
                            if (r_head[v_lv] == r_tail[v_lv]) begin
                                n_bitmap[v_lv] = 1'b0;
                            end else begin
                                n_head[v_lv] = r_next[r_head[v_lv]];
                            end
                            n_onq[v_pick] = 1'b0;
                            n_active_vld  = 1'b0;
                            v_exit        = 1'b1;
                        end
                    end
                    // rotate the configured level head to tail
                    if (!v_exit && r_bitmap[v_rl] && (r_head[v_rl] != r_tail[v_rl])) begin
                        v_h                  = r_head[v_rl];
                        n_next[r_tail[v_rl]] = v_h;
                        n_tail[v_rl]         = v_h;
                        n_head[v_rl]         = r_next[v_h];
                    end
                    o_result.picked_task   = v_pick;
                    o_result.exited        = v_exit;
                    o_result.picked_budget = v_pbud;
                end
            end
            OP_LOAD_BUDGET: begin
                n_budget[v_t] = i_item.budget;
            end
            OP_PREEMPT: begin
                v_take = !r_active_vld || !r_onq[r_active] ||
                         (r_level[r_active] > i_item.other_priority);
                if (v_take) begin
                    if (i_item.in_interrupt) begin
                        n_sw_req = 1'b1;
                    end else begin
                        o_result.yield_now = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.switch_pending = n_sw_req;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap     <= '0;
            r_onq        <= '0;
            r_active     <= '0;
            r_active_vld <= 1'b0;
            r_sw_req     <= 1'b0;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_next[i]   <= '0;
                r_level[i]  <= '0;
                r_budget[i] <= '0;
            end
        end else if (i_fire) begin
            r_bitmap     <= n_bitmap;
            r_onq        <= n_onq;
            r_active     <= n_active;
            r_active_vld <= n_active_vld;
            r_sw_req     <= n_sw_req;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_next       <= n_next;
            r_level      <= n_level;
            r_budget     <= n_budget;
        end
    end

endmodule

/* src/priority_bitmap_task_scheduler_core.sv */
// top level of the priority bitmap task scheduler: stream ports, register file, word registers
`timescale 1ns / 1ps

// Fixed-priority task scheduler with one FIFO of task ids per level. Words enter on the
// s_axis side (tuser selects set_status, schedule, load_budget or preempt_check) and each
// gives exactly one result word on the m_axis side. The block takes one word per cycle
// while the result side keeps up: a word is held in an input register, where the level
// lists, bitmap and budgets are read and updated, and the result lands in an output
// register, which drives m_axis. Input acceptance stalls only when both registers hold
// a word and the result is not being taken. The scheduler state clears at reset and the
// APB registers take their reset values; the APB registers must be written only
// while no word is in flight.

module priority_bitmap_task_scheduler_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: task_id[4:0], priority_req[8:5], to_runqueue[9], budget[25:10],
    //        other_priority[29:26], in_interrupt[30], zero[31]
    input  logic [pbts_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  logic [pbts_pkg::IN_USER_W-1:0]    s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: picked_task[4:0], idle[5], changed[6], exited[7], yield_now[8],
    //        switch_pending[9], picked_budget[25:10], zero[31:26]
    output logic [pbts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pbts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pbts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import pbts_pkg::*;

    logic             r_in_vld;
    t_item            r_in;
    logic             r_out_vld;
    t_result          r_out;
    t_cfg             r_cfg;
    t_result          w_result;
    logic             w_fire;
    logic [REG_IDX_W-1:0] w_idx;
    t_item            w_item;

    // handshake: the held word moves on when the output register has room
    assign w_fire        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_fire;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W - 26){1'b0}}, r_out.picked_budget,
                            r_out.switch_pending, r_out.yield_now, r_out.exited,
                            r_out.changed, r_out.idle, r_out.picked_task};

    // unpack the input word
    always_comb begin
        w_item.op             = t_op'(s_axis_tuser);
        w_item.task_id        = s_axis_tdata[4:0];
        w_item.priority_req   = s_axis_tdata[8:5];
        w_item.to_runqueue    = s_axis_tdata[9];
        w_item.budget         = s_axis_tdata[25:10];
        w_item.other_priority = s_axis_tdata[29:26];
        w_item.in_interrupt   = s_axis_tdata[30];
    end

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= w_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    // register file
    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slice_cost    <= RST_SLICE_COST;
            r_cfg.rotate_level  <= RST_ROTATE_LEVEL;
            r_cfg.exempt_first  <= RST_EXEMPT_FIRST;
            r_cfg.exempt_second <= RST_EXEMPT_SECOND;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_SLICE_COST:    r_cfg.slice_cost    <= pwdata[BUD_W-1:0];
                REG_ROTATE_LEVEL:  r_cfg.rotate_level  <= pwdata[LVL_W-1:0];
                REG_EXEMPT_FIRST:  r_cfg.exempt_first  <= pwdata[TASK_W-1:0];
                REG_EXEMPT_SECOND: r_cfg.exempt_second <= pwdata[TASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read mux
    always_comb begin
        case (w_idx)
            REG_SLICE_COST:    prdata = APB_DATA_W'(r_cfg.slice_cost);
            REG_ROTATE_LEVEL:  prdata = APB_DATA_W'(r_cfg.rotate_level);
            REG_EXEMPT_FIRST:  prdata = APB_DATA_W'(r_cfg.exempt_first);
            REG_EXEMPT_SECOND: prdata = APB_DATA_W'(r_cfg.exempt_second);
            default:           prdata = '0;
        endcase
    end

    // scheduler state and update
    pbts_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

endmodule
